FILE: sv/ray_triangle_intersect_macros.svh
// Assertion macros shared by the checker of the ray-triangle intersector.
// Depends on nothing; every macro samples on aclk and is disabled in reset.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Same-cycle implication.
`define RTI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rti_pkg.sv
// Types, widths and constants of the fixed-point ray-triangle intersector.
// Depends on nothing; used by every module of the block.
package rti_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int EW        = CW + 1;
    localparam int PW        = 2 * EW + 1;
    localparam int LO_W      = EW + 1;
    localparam int HI_W      = PW - LO_W;
    localparam int LOPP_W    = EW + LO_W + 1;
    localparam int HIPP_W    = EW + HI_W;
    localparam int DOTW      = 104;
    localparam int MAGW      = DOTW;
    localparam int QW        = 32;
    localparam int RW        = MAGW + QW;
    localparam int GEOM_LAT  = 7;
    localparam int DIV_LAT   = QW + 1;
    localparam int PIPE_LAT  = GEOM_LAT + DIV_LAT;

    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
    localparam logic [QW-1:0] T_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] T_MIN = {1'b1, {(QW-1){1'b0}}};

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_DET_EPS  = 3'd6;
    localparam logic [2:0] REG_CULL     = 3'd7;

    typedef logic signed [EW-1:0]   edge_t;
    typedef logic signed [2*EW-1:0] prod_t;
    typedef logic signed [PW-1:0]   crs_t;
    typedef logic signed [DOTW-1:0] dot_t;
    typedef logic [MAGW-1:0]        mag_t;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
    } tri_item_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] t_hit;
        logic [FRAC_BITS:0]   u_bary;
        logic [FRAC_BITS:0]   v_bary;
    } hit_item_t;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic [CW-2:0]        det_epsilon;
        logic                 cull_backfaces;
    } ray_cfg_t;

    localparam ray_cfg_t CFG_RESET = '{
        origin_x: '0, origin_y: '0, origin_z: '0,
        dir_x: '0, dir_y: '0, dir_z: CW'(ONE_Q),
        det_epsilon: (CW-1)'(1), cull_backfaces: 1'b0
    };

    typedef struct packed {
        logic miss;
        logic neg_u;
        logic neg_v;
        logic neg_t;
    } side_t;

    typedef struct packed {
        side_t side;
        mag_t  d_mag;
        mag_t  nu_mag;
        mag_t  nv_mag;
        mag_t  nt_mag;
    } geom_out_t;

    function automatic edge_t ext_edge(logic signed [CW-1:0] x);
        return {x[CW-1], x};
    endfunction

endpackage

FILE: sv/ray_triangle_intersect.sv
// Top level of the fixed-point ray-triangle intersector: ray registers, valid
// pipeline, three dividers and the output stage. Depends on rti_pkg, rti_geom, rti_div.
//
//   channel   ports                               carries
//   input     s_valid, s_ready, s_item            one triangle (three vertices)
//   result    m_valid, m_ready, m_item            hit, t_hit, u_bary, v_bary
//   config    cfg_we, cfg_index, cfg_wdata        ray, epsilon and culling registers
//
// One item is taken every cycle while no result waits at the output.
// The pipeline is made of the seven geometry stages and the 33 divider stages.
// Reset clears the valid pipeline and loads the register reset values.
// The whole pipeline holds while a result waits at the output.
module ray_triangle_intersect import rti_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [CW-1:0] cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  tri_item_t     s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output hit_item_t     m_item
);

    ray_cfg_t  cfg_reg;
    logic      en;
    logic      vld_reg [PIPE_LAT];
    side_t     side_reg [DIV_LAT];
    geom_out_t geom;
    logic [QW-1:0] qu, qv, qt;
    logic      ovf_u, ovf_v, ovf_t;
    side_t     side;
    logic      u_miss, v_miss, hit;
    logic [QW:0] uv_sum;
    logic [QW-1:0] t_val;
    hit_item_t m_item_next, m_item_reg;
    logic      m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X: cfg_reg.origin_x <= cfg_wdata;
                REG_ORIGIN_Y: cfg_reg.origin_y <= cfg_wdata;
                REG_ORIGIN_Z: cfg_reg.origin_z <= cfg_wdata;
                REG_DIR_X:    cfg_reg.dir_x <= cfg_wdata;
                REG_DIR_Y:    cfg_reg.dir_y <= cfg_wdata;
                REG_DIR_Z:    cfg_reg.dir_z <= cfg_wdata;
                REG_DET_EPS:  cfg_reg.det_epsilon <= cfg_wdata[CW-2:0];
                REG_CULL:     cfg_reg.cull_backfaces <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    rti_geom u_geom (
        .aclk   (aclk),
        .en     (en),
        .tri_i  (s_item),
        .cfg_i  (cfg_reg),
        .geom_o (geom)
    );

    rti_div u_div_u (
        .aclk (aclk), .en (en), .den_i (geom.d_mag), .num_i (geom.nu_mag),
        .quo_o (qu), .ovf_o (ovf_u)
    );

    rti_div u_div_v (
        .aclk (aclk), .en (en), .den_i (geom.d_mag), .num_i (geom.nv_mag),
        .quo_o (qv), .ovf_o (ovf_v)
    );

    rti_div u_div_t (
        .aclk (aclk), .en (en), .den_i (geom.d_mag), .num_i (geom.nt_mag),
        .quo_o (qt), .ovf_o (ovf_t)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= geom.side;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_comb begin
        side   = side_reg[DIV_LAT-1];
        u_miss = side.neg_u ? (ovf_u || qu != '0) : (ovf_u || qu > ONE_Q);
        uv_sum = {1'b0, qv} + {1'b0, qu};
        v_miss = side.neg_v ? (ovf_v || qv != '0)
                            : (ovf_v || uv_sum > {1'b0, ONE_Q});
        hit    = !side.miss && !u_miss && !v_miss;
        if (side.neg_t) begin
            t_val = (ovf_t || qt > T_MIN) ? T_MIN : -qt;
        end else begin
            t_val = (ovf_t || qt[QW-1]) ? T_MAX : qt;
        end
        m_item_next.hit    = hit;
        m_item_next.t_hit  = hit ? t_val : '0;
        m_item_next.u_bary = hit ? qu[FRAC_BITS:0] : '0;
        m_item_next.v_bary = hit ? qv[FRAC_BITS:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: sv/rti_geom.sv
// Edge, cross-product and dot-product stages plus the determinant test.
// Depends on rti_pkg; feeds the three dividers and the sideband delay line.
module rti_geom import rti_pkg::*; (
    input  logic      aclk,
    input  logic      en,
    input  tri_item_t tri_i,
    input  ray_cfg_t  cfg_i,
    output geom_out_t geom_o
);

    edge_t va [3], vb [3], vc [3], org [3], dirv [3];
    edge_t e1_reg [3], e2_reg [3], s_reg [3];
    edge_t e1b_reg [3], e2b_reg [3], sb_reg [3];
    edge_t e1c_reg [3], e2c_reg [3], sc_reg [3];
    prod_t pm_reg [6], qm_reg [6];
    crs_t  p_reg [3], q_reg [3];
    edge_t xop [4][3];
    crs_t  yop [4][3];
    logic signed [LOPP_W-1:0] lo_reg [4][3];
    logic signed [HIPP_W-1:0] hi_reg [4][3];
    dot_t  term_reg [4][3];
    dot_t  dot_reg [4];
    geom_out_t geom_next, geom_reg;
    mag_t  mag [4];
    logic  negs [4];
    mag_t  dtr_mag;
    logic  small_det;

    always_comb begin
        va[0] = ext_edge(tri_i.a_x); va[1] = ext_edge(tri_i.a_y); va[2] = ext_edge(tri_i.a_z);
        vb[0] = ext_edge(tri_i.b_x); vb[1] = ext_edge(tri_i.b_y); vb[2] = ext_edge(tri_i.b_z);
        vc[0] = ext_edge(tri_i.c_x); vc[1] = ext_edge(tri_i.c_y); vc[2] = ext_edge(tri_i.c_z);
        org[0] = ext_edge(cfg_i.origin_x);
        org[1] = ext_edge(cfg_i.origin_y);
        org[2] = ext_edge(cfg_i.origin_z);
        dirv[0] = ext_edge(cfg_i.dir_x);
        dirv[1] = ext_edge(cfg_i.dir_y);
        dirv[2] = ext_edge(cfg_i.dir_z);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                e1_reg[j] <= vb[j] - va[j];
                e2_reg[j] <= vc[j] - va[j];
                s_reg[j]  <= org[j] - va[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_reg[0] <= dirv[1] * e2_reg[2];
            pm_reg[1] <= dirv[2] * e2_reg[1];
            pm_reg[2] <= dirv[2] * e2_reg[0];
            pm_reg[3] <= dirv[0] * e2_reg[2];
            pm_reg[4] <= dirv[0] * e2_reg[1];
            pm_reg[5] <= dirv[1] * e2_reg[0];
            qm_reg[0] <= s_reg[1] * e1_reg[2];
            qm_reg[1] <= s_reg[2] * e1_reg[1];
            qm_reg[2] <= s_reg[2] * e1_reg[0];
            qm_reg[3] <= s_reg[0] * e1_reg[2];
            qm_reg[4] <= s_reg[0] * e1_reg[1];
            qm_reg[5] <= s_reg[1] * e1_reg[0];
            for (int j = 0; j < 3; j++) begin
                e1b_reg[j] <= e1_reg[j];
                e2b_reg[j] <= e2_reg[j];
                sb_reg[j]  <= s_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                p_reg[j]   <= crs_t'(pm_reg[2*j]) - crs_t'(pm_reg[2*j+1]);
                q_reg[j]   <= crs_t'(qm_reg[2*j]) - crs_t'(qm_reg[2*j+1]);
                e1c_reg[j] <= e1b_reg[j];
                e2c_reg[j] <= e2b_reg[j];
                sc_reg[j]  <= sb_reg[j];
            end
        end
    end

    // Dot products order: determinant, u, v and t numerators.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            xop[0][j] = e1c_reg[j]; yop[0][j] = p_reg[j];
            xop[1][j] = sc_reg[j];  yop[1][j] = p_reg[j];
            xop[2][j] = dirv[j];    yop[2][j] = q_reg[j];
            xop[3][j] = e2c_reg[j]; yop[3][j] = q_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    lo_reg[k][j] <= xop[k][j] * $signed({1'b0, yop[k][j][LO_W-1:0]});
                    hi_reg[k][j] <= xop[k][j] * $signed(yop[k][j][PW-1:LO_W]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    term_reg[k][j] <= (dot_t'(hi_reg[k][j]) <<< LO_W) + dot_t'(lo_reg[k][j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                dot_reg[k] <= term_reg[k][0] + term_reg[k][1] + term_reg[k][2];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            negs[k] = dot_reg[k][DOTW-1];
            mag[k]  = negs[k] ? mag_t'(-dot_reg[k]) : mag_t'(dot_reg[k]);
        end
        dtr_mag   = mag[0] >> (2 * FRAC_BITS);
        small_det = dtr_mag < mag_t'(cfg_i.det_epsilon);
        geom_next.side.miss = (dot_reg[0] == '0)
                            || (cfg_i.cull_backfaces ? ((negs[0] && dtr_mag != '0) || small_det)
                                                     : small_det);
        geom_next.side.neg_u = negs[1] ^ negs[0];
        geom_next.side.neg_v = negs[2] ^ negs[0];
        geom_next.side.neg_t = negs[3] ^ negs[0];
        geom_next.d_mag  = mag[0];
        geom_next.nu_mag = mag[1];
        geom_next.nv_mag = mag[2];
        geom_next.nt_mag = mag[3];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geom_reg <= geom_next;
        end
    end

    assign geom_o = geom_reg;

endmodule

FILE: sv/rti_div.sv
// Pipelined restoring divider: (numerator << FRAC_BITS) / denominator, one bit a stage.
// Depends on rti_pkg; gives a QW-bit magnitude quotient and an overflow flag.
module rti_div import rti_pkg::*; (
    input  logic          aclk,
    input  logic          en,
    input  mag_t          den_i,
    input  mag_t          num_i,
    output logic [QW-1:0] quo_o,
    output logic          ovf_o
);

    logic [RW-1:0] rem_reg [QW];
    mag_t          den_reg [QW];
    logic [QW-1:0] quo_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic [RW-1:0] num_sh;

    assign num_sh = RW'(num_i) << FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_sh;
            den_reg[0] <= den_i;
            quo_reg[0] <= '0;
            ovf_reg[0] <= num_sh >= (RW'(den_i) << QW);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW-1:0] shd;
        logic          ge;
        assign shd = RW'(den_reg[k]) << (QW - 1 - k);
        assign ge  = rem_reg[k] >= shd;

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k+1] <= quo_reg[k] | (QW'(ge) << (QW - 1 - k));
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? rem_reg[k] - shd : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign quo_o = quo_reg[QW];
    assign ovf_o = ovf_reg[QW];

endmodule

FILE: sv/rti_checker.sv
// Port-level checks of the ray-triangle intersector and the bind that attaches them.
// Depends on rti_pkg and ray_triangle_intersect_macros.svh.
`include "ray_triangle_intersect_macros.svh"

module rti_checker import rti_pkg::*; (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input hit_item_t     m_item
);

    `RTI_ASSERT_IMP(a_miss_zero, m_valid && !m_item.hit, m_item.t_hit == '0 && m_item.u_bary == '0 && m_item.v_bary == '0, "miss item carries non-zero fields")
    `RTI_ASSERT_IMP(a_bary_range, m_valid && m_item.hit, ({1'b0, m_item.u_bary} + {1'b0, m_item.v_bary}) <= (FRAC_BITS+2)'(ONE_Q), "barycentric weights exceed one")
    `RTI_ASSERT_IMP(a_no_backpressure, m_ready, s_ready, "input stalled while output drains")
    `RTI_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_item), "stalled result changed")

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

FILE: bench/ray_triangle_intersect_test.sv
// Self-checking bench for the fixed-point ray-triangle intersector.
// Depends on rti_pkg and ray_triangle_intersect; predicts each result with exact
// wide arithmetic and compares it with the whole result item in arrival order.
`timescale 1ns / 100ps

module ray_triangle_intersect_test;
    import rti_pkg::*;

    typedef logic signed [191:0] wide_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [CW-1:0] cfg_wdata = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    tri_item_t     s_item = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    hit_item_t     m_item;

    ray_cfg_t      ray = CFG_RESET;
    hit_item_t     expected_hits[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    bit            idle_enable = 1'b1;

    ray_triangle_intersect u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 300000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic wide_t quotient(wide_t num, wide_t den);
        wide_t n;
        wide_t d;
        wide_t q;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (n <<< FRAC_BITS) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic hit_item_t predict_hit(tri_item_t tr);
        hit_item_t r;
        wide_t ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, dx, dy, dz, sx, sy, sz;
        wide_t px, py, pz, qx, qy, qz, det, dtr, u, v, t;
        r = '0;
        ax = tr.a_x; ay = tr.a_y; az = tr.a_z;
        e1x = wide_t'(tr.b_x) - ax; e1y = wide_t'(tr.b_y) - ay; e1z = wide_t'(tr.b_z) - az;
        e2x = wide_t'(tr.c_x) - ax; e2y = wide_t'(tr.c_y) - ay; e2z = wide_t'(tr.c_z) - az;
        dx = ray.dir_x; dy = ray.dir_y; dz = ray.dir_z;
        sx = wide_t'(ray.origin_x) - ax;
        sy = wide_t'(ray.origin_y) - ay;
        sz = wide_t'(ray.origin_z) - az;
        px = dy * e2z - dz * e2y; py = dz * e2x - dx * e2z; pz = dx * e2y - dy * e2x;
        det = e1x * px + e1y * py + e1z * pz;
        if (det == 0) return r;
        dtr = det < 0 ? -((-det) >>> (2 * FRAC_BITS)) : det >>> (2 * FRAC_BITS);
        if (ray.cull_backfaces) begin
            if (dtr < wide_t'({1'b0, ray.det_epsilon})) return r;
        end else if ((dtr < 0 ? -dtr : dtr) < wide_t'({1'b0, ray.det_epsilon})) begin
            return r;
        end
        u = quotient(sx * px + sy * py + sz * pz, det);
        if (u < 0 || u > (wide_t'(1) <<< FRAC_BITS)) return r;
        qx = sy * e1z - sz * e1y; qy = sz * e1x - sx * e1z; qz = sx * e1y - sy * e1x;
        v = quotient(dx * qx + dy * qy + dz * qz, det);
        if (v < 0 || u + v > (wide_t'(1) <<< FRAC_BITS)) return r;
        t = quotient(e2x * qx + e2y * qy + e2z * qz, det);
        if (t > wide_t'(32'sh7fffffff)) t = 32'sh7fffffff;
        if (t < -(wide_t'(1) <<< 31)) t = -(wide_t'(1) <<< 31);
        r.hit = 1'b1;
        r.t_hit = t[31:0];
        r.u_bary = u[16:0];
        r.v_bary = v[16:0];
        return r;
    endfunction

    task automatic idle_burst();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    endtask

    task automatic send_triangle(tri_item_t tr);
        idle_burst();
        s_item <= tr;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_hits = {expected_hits, predict_hit(tr)};
        @(negedge aclk);
    endtask

    always begin
        @(negedge aclk);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        hit_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t unexpected result %p", $time, m_item);
                fail_count++;
            end else begin
                want = expected_hits.pop_front();
                if (m_item !== want) begin
                    $display("%0t expected %p actual %p", $time, want, m_item);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] index, logic [CW-1:0] value);
        cfg_index <= index;
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge aclk);
        case (index)
            REG_ORIGIN_X: ray.origin_x = value;
            REG_ORIGIN_Y: ray.origin_y = value;
            REG_ORIGIN_Z: ray.origin_z = value;
            REG_DIR_X:    ray.dir_x = value;
            REG_DIR_Y:    ray.dir_y = value;
            REG_DIR_Z:    ray.dir_z = value;
            REG_DET_EPS:  ray.det_epsilon = value[CW-2:0];
            REG_CULL:     ray.cull_backfaces = value[0];
            default: begin
            end
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_hits.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 10) @(negedge aclk);
    endtask

    task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                           int eps, bit cull);
        drain();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_DET_EPS, eps);
        write_reg(REG_CULL, CW'(cull));
        cfg_we <= 1'b0;
    endtask

    function automatic tri_item_t make_tri(int ax, int ay, int az, int bx, int by,
                                           int bz, int cx, int cy, int cz);
        tri_item_t tr;
        tr.a_x = ax; tr.a_y = ay; tr.a_z = az;
        tr.b_x = bx; tr.b_y = by; tr.b_z = bz;
        tr.c_x = cx; tr.c_y = cy; tr.c_z = cz;
        return tr;
    endfunction

    // A triangle around the ray axis at the scale set by span, so that hits are common.
    function automatic tri_item_t random_facing_tri(int span);
        tri_item_t tr;
        int z;
        z = $urandom_range(0, 2 * span) - span;
        tr = make_tri(-$urandom_range(1, span), -$urandom_range(1, span), z,
                      $urandom_range(1, span), -$urandom_range(1, span),
                      z + $urandom_range(0, 4096) - 2048,
                      $urandom_range(0, span) - span / 2, $urandom_range(1, span),
                      z + $urandom_range(0, 4096) - 2048);
        if ($urandom_range(0, 1)) begin
            tr.b_x = tr.c_x; tr.b_y = tr.c_y;
            tr.c_x = $urandom_range(1, span); tr.c_y = -$urandom_range(1, span);
        end
        return tr;
    endfunction

    task automatic test_directed();
        int big;
        big = 32'h7fffffff;
        send_triangle(make_tri(-65536, -65536, 131072, 65536, -65536, 131072,
                               0, 65536, 131072));
        send_triangle(make_tri(-65536, -65536, 131072, 0, 65536, 131072,
                               65536, -65536, 131072));
        send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        send_triangle(make_tri(131072, 131072, 0, 196608, 131072, 0, 131072, 196608, 0));
        send_triangle(make_tri(0, 0, 0, 65536, 0, 65536, 131072, 0, 131072));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(1, 1, 0, -1, 1, 0, 0, -1, 0));
        send_triangle(make_tri(-big - 1, -big - 1, big, big, -big - 1, big,
                               0, big, -big - 1));
        send_triangle(make_tri(big, big, big, -big - 1, -big - 1, -big - 1,
                               big, -big - 1, big));
        send_triangle(make_tri(-big - 1, big, -big - 1, big, big, big,
                               -big - 1, -big - 1, big));
        send_triangle(make_tri(-1, -1, big, 1, -1, big, 0, 1, big));
        set_ray(0, 0, 0, 0, 0, 65536, 0, 1);
        send_triangle(make_tri(-65536, -65536, 65536, 65536, -65536, 65536,
                               0, 65536, 65536));
        send_triangle(make_tri(-65536, -65536, 65536, 0, 65536, 65536,
                               65536, -65536, 65536));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 65536, 65536, 0));
        set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 1, 32'h7fffffff, 0);
        send_triangle(make_tri(-big - 1, -big - 1, big, big, -big - 1, big,
                               0, big, -big - 1));
        send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        set_ray(0, 0, -32'h7fff0000, 0, 0, 1, 0, 0);
        send_triangle(make_tri(-65536, -65536, 65536, 65536, -65536, 65536,
                               0, 65536, 65536));
    endtask

    task automatic test_random(int count, bit structured);
        tri_item_t tr;
        for (int i = 0; i < count; i++) begin
            if (structured && $urandom_range(0, 9) < 8) begin
                tr = random_facing_tri($urandom_range(0, 1) ? 65536 * 4 : 32'h40000000);
            end else begin
                tr = make_tri($urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
            end
            send_triangle(tr);
        end
    endtask

    task automatic test_random_rays();
        for (int phase = 0; phase < 4; phase++) begin
            set_ray($urandom_range(0, 65536) - 32768, $urandom_range(0, 65536) - 32768,
                    -$urandom_range(0, 32'h40000), $urandom_range(0, 8192) - 4096,
                    $urandom_range(0, 8192) - 4096, $urandom_range(1, 32'h20000),
                    $urandom_range(0, 4), 1'($urandom_range(0, 1)));
            test_random(70, 1'b1);
        end
        set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, 1'($urandom));
        test_random(40, 1'b0);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        set_ray(0, 0, 0, 0, 0, 65536, 1, 0);
        test_random(40, 1'b1);
        test_random_rays();
        idle_enable = 1'b0;
        set_ray(0, 0, 0, 0, 0, 65536, 1, 1);
        test_random(40, 1'b1);
        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: ray_triangle_intersect.f
+incdir+sv
sv/rti_pkg.sv
sv/rti_geom.sv
sv/rti_div.sv
sv/ray_triangle_intersect.sv
sv/rti_checker.sv
bench/ray_triangle_intersect_test.sv
